[src/ipdt_pkg.sv]
// ----------------------------------------------------------------------------
// ipdt_pkg
// Shared types and constants of the pulse-distance IR transmitter.
// ----------------------------------------------------------------------------
package ipdt_pkg;

  localparam int unsigned SYS_CODE_W  = 26;
  localparam int unsigned CMD_W       = 8;
  localparam int unsigned SHORT_CNT_W = 12;
  localparam int unsigned GAP_CNT_W   = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 26;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 3'd6;

  // Reset values of the registers
  localparam logic [SYS_CODE_W-1:0]  RST_SYSTEM_CODE  = 26'd64790810;
  localparam logic [SHORT_CNT_W-1:0] RST_LEADER_MARK  = 12'd326;
  localparam logic [SHORT_CNT_W-1:0] RST_LEADER_SPACE = 12'd170;
  localparam logic [SHORT_CNT_W-1:0] RST_BIT_MARK     = 12'd16;
  localparam logic [SHORT_CNT_W-1:0] RST_ONE_SPACE    = 12'd59;
  localparam logic [SHORT_CNT_W-1:0] RST_ZERO_SPACE   = 12'd18;
  localparam logic [GAP_CNT_W-1:0]   RST_GAP          = 16'd1769;

  typedef enum logic [3:0] {
    SEG_IDLE       = 4'd0,
    SEG_LEAD_MARK  = 4'd1,
    SEG_LEAD_SPACE = 4'd2,
    SEG_BIT_MARK   = 4'd3,
    SEG_BIT_SPACE  = 4'd4,
    SEG_STOP_MARK  = 4'd5,
    SEG_GAP        = 4'd6,
    SEG_REP_MARK   = 4'd7,
    SEG_REP_SPACE  = 4'd8,
    SEG_REP_STOP   = 4'd9
  } segment_e;

  typedef struct packed {
    logic [SYS_CODE_W-1:0]  system_code;
    logic [SHORT_CNT_W-1:0] leader_mark;
    logic [SHORT_CNT_W-1:0] leader_space;
    logic [SHORT_CNT_W-1:0] bit_mark;
    logic [SHORT_CNT_W-1:0] one_space;
    logic [SHORT_CNT_W-1:0] zero_space;
    logic [GAP_CNT_W-1:0]   gap;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy;
  } res_t;

  function automatic logic is_mark(segment_e seg);
    return (seg == SEG_LEAD_MARK) || (seg == SEG_BIT_MARK) || (seg == SEG_STOP_MARK) ||
           (seg == SEG_REP_MARK) || (seg == SEG_REP_STOP);
  endfunction

endpackage

[src/ir_pulse_distance_transmitter_top.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_top - pulse-distance IR remote transmitter
// An input transfer's result is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle while the output channel does not stall.
// Reset: async active low; sequencer idle, carrier high, no result valid, registers at defaults.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_top #(
  parameter int unsigned SYSTEM_CODE_BITS = 26,
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel: one tick or one send request per transfer
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [ipdt_pkg::CMD_W-1:0]      command_i,
  // output channel: pin level and busy flag per transfer
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ir_level_o,
  output logic                            busy_res_o
);
  import ipdt_pkg::*;

  cfg_t cfg;
  res_t seq_res;
  res_t out_res;
  logic step;

  // Timing counts and system code. A write takes effect at the next edge,
  // also in the middle of a frame (the running segment uses the new count).
  ipdt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer walks leader, data bits, stop, gap and repeat frame. Each
  // accepted transfer steps it at most once (a send outside idle is dropped); the result for that transfer
  // comes out of the same combinational pass.
  ipdt_seq #(
    .SYSTEM_CODE_BITS (SYSTEM_CODE_BITS),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .action_i  (action_i),
    .command_i (command_i),
    .cfg_i     (cfg),
    .res_o     (seq_res)
  );

  // Result register decouples the sink. A new transfer is taken whenever the
  // register is empty or draining this cycle, so ticks flow back to back.
  ipdt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_i       (seq_res),
    .step_o      (step),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign ir_level_o = out_res.ir_level;
  assign busy_res_o = out_res.busy;

endmodule

[src/ipdt_cfg.sv]
// ----------------------------------------------------------------------------
// ipdt_cfg
// Timing and system code registers behind the plain write port.
// ----------------------------------------------------------------------------
module ipdt_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ipdt_pkg::cfg_t                  cfg_o
);
  import ipdt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYSTEM_CODE:  cfg_d.system_code  = cfg_wdata_i[SYS_CODE_W-1:0];
        CFG_LEADER_MARK:  cfg_d.leader_mark  = cfg_wdata_i[SHORT_CNT_W-1:0];
        CFG_LEADER_SPACE: cfg_d.leader_space = cfg_wdata_i[SHORT_CNT_W-1:0];
        CFG_BIT_MARK:     cfg_d.bit_mark     = cfg_wdata_i[SHORT_CNT_W-1:0];
        CFG_ONE_SPACE:    cfg_d.one_space    = cfg_wdata_i[SHORT_CNT_W-1:0];
        CFG_ZERO_SPACE:   cfg_d.zero_space   = cfg_wdata_i[SHORT_CNT_W-1:0];
        CFG_GAP:          cfg_d.gap          = cfg_wdata_i[GAP_CNT_W-1:0];
        default:          cfg_d = cfg_q; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.system_code  <= RST_SYSTEM_CODE;
      cfg_q.leader_mark  <= RST_LEADER_MARK;
      cfg_q.leader_space <= RST_LEADER_SPACE;
      cfg_q.bit_mark     <= RST_BIT_MARK;
      cfg_q.one_space    <= RST_ONE_SPACE;
      cfg_q.zero_space   <= RST_ZERO_SPACE;
      cfg_q.gap          <= RST_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/ipdt_seq.sv]
// ----------------------------------------------------------------------------
// ipdt_seq
// Frame sequencer: segment state, tick counter, carrier and payload shifter.
// ----------------------------------------------------------------------------
module ipdt_seq #(
  parameter int unsigned SYSTEM_CODE_BITS = 26,
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       action_i,
  input  logic [ipdt_pkg::CMD_W-1:0] command_i,
  input  ipdt_pkg::cfg_t             cfg_i,
  output ipdt_pkg::res_t             res_o
);
  import ipdt_pkg::*;

  localparam int unsigned PAY_W  = SYSTEM_CODE_BITS + 2 * CMD_W;
  localparam int unsigned BL_W   = $clog2(PAY_W + 1);
  localparam int unsigned CMP_W  = 25;
  localparam logic [BL_W-1:0]             BITS_TOTAL = BL_W'(PAY_W);
  localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX    = {TICK_COUNT_WIDTH{1'b1}};

  segment_e                    seg_q, seg_d;
  logic [BL_W-1:0]             bits_left_q, bits_left_d, bits_dec;
  logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_d, seg_len;
  logic                        carrier_q, carrier_d, level;
  logic [PAY_W-1:0]            payload_q, payload_d;
  logic [SYSTEM_CODE_BITS+SYS_CODE_W-1:0] sys_ext;
  logic [GAP_CNT_W-1:0]        raw_len;
  logic [CMP_W-1:0]            raw_len_ext;
  logic                        busy;

  assign sys_ext = {{SYSTEM_CODE_BITS{1'b0}}, cfg_i.system_code};

  // Length of the running segment: zero reads as one, clipped to counter range
  always_comb begin
    unique case (seg_q)
      SEG_LEAD_MARK, SEG_REP_MARK:
        raw_len = GAP_CNT_W'(cfg_i.leader_mark);
      SEG_LEAD_SPACE, SEG_REP_SPACE:
        raw_len = GAP_CNT_W'(cfg_i.leader_space);
      SEG_BIT_MARK, SEG_STOP_MARK, SEG_REP_STOP:
        raw_len = GAP_CNT_W'(cfg_i.bit_mark);
      SEG_BIT_SPACE:
        raw_len = payload_q[0] ? GAP_CNT_W'(cfg_i.one_space) : GAP_CNT_W'(cfg_i.zero_space);
      default:
        raw_len = cfg_i.gap;
    endcase
    raw_len_ext = CMP_W'(raw_len);
    if (raw_len == '0) begin
      seg_len = TICK_COUNT_WIDTH'(1);
    end else if (raw_len_ext > CMP_W'(CNT_MAX)) begin
      seg_len = CNT_MAX;
    end else begin
      seg_len = raw_len_ext[TICK_COUNT_WIDTH-1:0];
    end
  end

  assign bits_dec = (bits_left_q != '0) ? bits_left_q - BL_W'(1) : bits_left_q;

  always_comb begin
    seg_d       = seg_q;
    bits_left_d = bits_left_q;
    tick_d      = tick_q;
    carrier_d   = carrier_q;
    payload_d   = payload_q;
    level       = carrier_q;
    busy        = 1'b1;
    if (action_i) begin
      // send: only loads a frame when idle, otherwise dropped
      if (seg_q == SEG_IDLE) begin
        payload_d   = {~command_i, command_i, sys_ext[SYSTEM_CODE_BITS-1:0]};
        bits_left_d = BITS_TOTAL;
        seg_d       = SEG_LEAD_MARK;
        tick_d      = '0;
        carrier_d   = 1'b1;
      end
      level = carrier_d;
    end else if (seg_q == SEG_IDLE) begin
      carrier_d = 1'b1;
      level     = 1'b1;
      busy      = 1'b0;
    end else begin
      carrier_d = is_mark(seg_q) ? ~carrier_q : 1'b1;
      level     = carrier_d;
      tick_d    = tick_q + TICK_COUNT_WIDTH'(1);
      if (tick_d >= seg_len) begin
        tick_d    = '0;
        carrier_d = 1'b1;
        unique case (seg_q)
          SEG_LEAD_MARK:  seg_d = SEG_LEAD_SPACE;
          SEG_LEAD_SPACE: seg_d = (bits_left_q != '0) ? SEG_BIT_MARK : SEG_STOP_MARK;
          SEG_BIT_MARK:   seg_d = SEG_BIT_SPACE;
          SEG_BIT_SPACE: begin
            payload_d   = payload_q >> 1;
            bits_left_d = bits_dec;
            seg_d       = (bits_dec != '0) ? SEG_BIT_MARK : SEG_STOP_MARK;
          end
          SEG_STOP_MARK:  seg_d = SEG_GAP;
          SEG_GAP:        seg_d = SEG_REP_MARK;
          SEG_REP_MARK:   seg_d = SEG_REP_SPACE;
          SEG_REP_SPACE:  seg_d = SEG_REP_STOP;
          default:        seg_d = SEG_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_IDLE;
      bits_left_q <= '0;
      tick_q      <= '0;
      carrier_q   <= 1'b1;
    end else if (step_i) begin
      seg_q       <= seg_d;
      bits_left_q <= bits_left_d;
      tick_q      <= tick_d;
      carrier_q   <= carrier_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      payload_q <= payload_d;
    end
  end

  assign res_o.ir_level = level;
  assign res_o.busy     = busy;

endmodule

[src/ipdt_out_reg.sv]
// ----------------------------------------------------------------------------
// ipdt_out_reg
// Result register with valid flag; holds a result while the sink stalls.
// ----------------------------------------------------------------------------
module ipdt_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ipdt_pkg::res_t res_i,
  output logic           step_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ipdt_pkg::res_t res_o
);
  import ipdt_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // upstream stalls only while a held result cannot leave
  assign in_stall_o = valid_q & out_stall_i;
  assign step_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (step_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[src/ipdt_checker.sv]
// ----------------------------------------------------------------------------
// ipdt_checker
// Port-level checks of the IR transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module ipdt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic action_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic ir_level_o,
  input logic busy_res_o
);

  // idle result always shows the pin high
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> ir_level_o)
    else $error("idle result with pin low");

  // input only stalls when a held result is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // a send transfer always reports busy on the next cycle
  a_send_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i |=> out_valid_o && busy_res_o)
    else $error("send transfer not reported busy");

  // a held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ir_level_o) && $stable(busy_res_o))
    else $error("stalled result changed");

endmodule

bind ir_pulse_distance_transmitter_top ipdt_checker u_ipdt_checker (.*);
